// File: rtl/core/pff_pkg.sv
`default_nettype none

package pff_pkg;

    localparam int POOL_SIZE_DEF = 16;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_DUP   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_ALLOC_RD,
        S_SCAN,
        S_PUSH
    } pff_state_t;

endpackage

`default_nettype wire

// File: rtl/core/packet_pool_free_list_top.sv
`default_nettype none

// Free-list allocator for a pool of POOL_SIZE buffer slots, kept as a LIFO
// stack of free slot numbers in a single-port-read / single-port-write RAM.
//
// Command channel: a transaction is taken on a rising edge with start high
// and busy low (opcode: allocate, release, query; slot_index for release).
// Result channel: done is high for exactly one cycle with status,
// granted_slot and free_count; the receiver cannot stall it.
//
// Query, failed allocate and out-of-range release answer straight from the idle
// state; a successful allocate reads the RAM once, then answers. A release
// scans the stack for a duplicate, one stack entry per cycle through the RAM
// read port, stopping at a match, then writes the slot in the push state; when
// the pool is empty it goes straight to the push.
// A new command can be taken in the cycle done is high.
//
// After reset the block is busy while the RAM is filled so that slot 0 is
// handed out first, then 1, and so on.
module packet_pool_free_list_top #(
    parameter int POOL_SIZE = pff_pkg::POOL_SIZE_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] slot_index,
    output logic            done,
    output logic [2:0]      status,
    output logic [7:0]      granted_slot,
    output logic [8:0]      free_count
);

    import pff_pkg::*;

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int TW = $clog2(POOL_SIZE + 1);

    logic [AW-1:0] mem [POOL_SIZE];
    logic [AW-1:0] rd_data_reg;

    pff_state_t    state_reg, state_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    granted_reg, granted_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr, wr_data;
    logic          accept, in_range, hit, scan_more, fill_last;

    assign accept    = start && (state_reg == S_IDLE);
    assign in_range  = {1'b0, slot_index} < 9'(POOL_SIZE);
    assign hit       = cmp_vld_reg && (rd_data_reg == slot_reg);
    assign scan_more = idx_reg < total_reg;
    assign fill_last = idx_reg == TW'(POOL_SIZE - 1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_FILL;
            total_reg   <= TW'(POOL_SIZE);
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:
            begin
                if (fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ALLOC && total_reg != '0)
                    begin
                        state_next = S_ALLOC_RD;
                    end
                    else if (opcode == OP_RELEASE && in_range)
                    begin
                        state_next = (total_reg == '0) ? S_PUSH : S_SCAN;
                    end
                end
            end
            S_ALLOC_RD:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_IDLE;
                end
                else if (!scan_more)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        total_next   = total_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        slot_next    = slot_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        granted_next = granted_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = AW'(POOL_SIZE - 1) - idx_reg[AW-1:0];
        case (state_reg)
            S_FILL:
            begin
                wr_en    = 1'b1;
                idx_next = fill_last ? '0 : idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next    = slot_index[AW-1:0];
                    idx_next     = '0;
                    granted_next = '0;
                    status_next  = ST_OK;
                    if (opcode == OP_ALLOC)
                    begin
                        if (total_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(total_reg - 1'b1);
                            total_next = total_reg - 1'b1;
                        end
                    end
                    else if (opcode == OP_RELEASE)
                    begin
                        if (!in_range)
                        begin
                            status_next = ST_RANGE;
                            done_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_ALLOC_RD:
            begin
                granted_next = 8'(rd_data_reg);
                status_next  = ST_OK;
                done_next    = 1'b1;
            end
            S_SCAN:
            begin
                // read of entry idx overlaps the compare of entry idx-1
                if (hit)
                begin
                    status_next = ST_DUP;
                    done_next   = 1'b1;
                end
                else if (scan_more)
                begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
            end
            S_PUSH:
            begin
                done_next = 1'b1;
                if (total_reg >= TW'(POOL_SIZE))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = total_reg[AW-1:0];
                    wr_data     = slot_reg;
                    total_next  = total_reg + 1'b1;
                    status_next = ST_OK;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign free_count   = 9'(total_reg);

endmodule

`default_nettype wire

// File: bench/tb_packet_pool_free_list_top.sv
`timescale 1ns / 100ps

module tb_packet_pool_free_list_top;

    import pff_pkg::*;

    localparam int POOL = POOL_SIZE_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RAND_ITEMS = 1400;
    localparam int QUIET_FROM = 1200;
    localparam int STALL_LIMIT = 400;
    localparam int SHOWN_MAX = 10;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] slot;
        logic [8:0] count;
    } pool_reply_t;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  slot;
        bit          fixed;
        pool_reply_t want;
    } cmd_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] opcode = OP_QUERY;
    logic [7:0] slot_index = 8'd0;
    logic       busy;
    logic       done;
    logic [2:0] status;
    logic [7:0] granted_slot;
    logic [8:0] free_count;

    // side info traveling with the command currently on the bus
    bit          cmd_fixed = 1'b0;
    pool_reply_t cmd_want = '0;

    // shadow of the pool: free slot numbers as a LIFO, bottom at index 0
    logic [7:0]  free_slots [POOL];
    int          free_depth;

    pool_reply_t owed_results[$];
    int          bad_results = 0;
    int          stall_cycles = 0;

    cmd_row_t dir_rows [25] = '{
        '{OP_QUERY,   8'd0,   1'b1, '{ST_OK,    8'd0,  9'd16}},
        '{OP_UNUSED,  8'd0,   1'b1, '{ST_OK,    8'd0,  9'd16}},
        '{OP_RELEASE, 8'd0,   1'b1, '{ST_DUP,   8'd0,  9'd16}},
        '{OP_RELEASE, 8'd255, 1'b1, '{ST_RANGE, 8'd0,  9'd16}},
        '{OP_RELEASE, 8'd16,  1'b1, '{ST_RANGE, 8'd0,  9'd16}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd0,  9'd15}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd1,  9'd14}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd2,  9'd13}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd3,  9'd12}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd4,  9'd11}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd5,  9'd10}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd6,  9'd9}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd7,  9'd8}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd8,  9'd7}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd9,  9'd6}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd10, 9'd5}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd11, 9'd4}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd12, 9'd3}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd13, 9'd2}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd14, 9'd1}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_OK,    8'd15, 9'd0}},
        '{OP_ALLOC,   8'd0,   1'b1, '{ST_EMPTY, 8'd0,  9'd0}},
        '{OP_RELEASE, 8'd15,  1'b1, '{ST_OK,    8'd0,  9'd1}},
        '{OP_RELEASE, 8'd7,   1'b0, '0},
        '{OP_ALLOC,   8'd0,   1'b0, '0}
    };

    packet_pool_free_list_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .slot_index   (slot_index),
        .done         (done),
        .status       (status),
        .granted_slot (granted_slot),
        .free_count   (free_count)
    );

    always #5 clk = ~clk;

    function automatic pool_reply_t pool_apply(logic [1:0] op, logic [7:0] slot);
        pool_reply_t r;
        bit          on_stack;
        int          i;
        r = '0;
        r.status = ST_OK;
        on_stack = 1'b0;
        if (op == OP_ALLOC) begin
            if (free_depth == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                free_depth--;
                r.slot = free_slots[free_depth];
            end
        end
        else if (op == OP_RELEASE) begin
            if (slot >= POOL) begin
                r.status = ST_RANGE;
            end
            else begin
                for (i = 0; i < free_depth; i++)
                    if (free_slots[i] == slot)
                        on_stack = 1'b1;
                if (on_stack) begin
                    r.status = ST_DUP;
                end
                else if (free_depth >= POOL) begin
                    r.status = ST_FULL;
                end
                else begin
                    free_slots[free_depth] = slot;
                    free_depth++;
                end
            end
        end
        r.count = free_depth[8:0];
        return r;
    endfunction

    function automatic bit slot_on_stack(int s);
        int i;
        for (i = 0; i < free_depth; i++)
            if (free_slots[i] == s)
                return 1'b1;
        return 1'b0;
    endfunction

    // mostly slots that are really out, with some double frees and junk
    function automatic logic [7:0] pick_release_slot();
        int held[$];
        int idle[$];
        int s;
        int pick;
        for (s = 0; s < POOL; s++) begin
            if (slot_on_stack(s))
                idle.push_back(s);
            else
                held.push_back(s);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'($urandom_range(POOL, 255));
        if (pick == 1)
            return 8'($urandom_range(0, 255));
        if (pick == 2 && idle.size() != 0)
            return 8'(idle[$urandom_range(0, idle.size() - 1)]);
        if (held.size() != 0)
            return 8'(held[$urandom_range(0, held.size() - 1)]);
        return 8'($urandom_range(0, POOL - 1));
    endfunction

    task automatic log_mismatch(string what, pool_reply_t want, pool_reply_t got);
        bad_results++;
        if (bad_results <= SHOWN_MAX)
            $display("%0t: %s: exp st=%0d slot=%0d cnt=%0d, got st=%0d slot=%0d cnt=%0d",
                     $realtime, what, want.status, want.slot, want.count,
                     got.status, got.slot, got.count);
    endtask

    task automatic send_cmd(logic [1:0] op, logic [7:0] slot, bit fixed,
                            pool_reply_t want, bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 13);
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start      <= 1'b1;
        opcode     <= op;
        slot_index <= slot;
        cmd_fixed  <= fixed;
        cmd_want   <= want;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // result check first, then take the new transaction: a command can be
    // accepted in the same cycle that an older result is on the bus
    always @(posedge clk) begin
        pool_reply_t got;
        pool_reply_t want;
        if (rst_n) begin
            if (done) begin
                got = '{status, granted_slot, free_count};
                if (owed_results.size() == 0) begin
                    log_mismatch("unexpected result", '0, got);
                end
                else begin
                    want = owed_results.pop_front();
                    if (got !== want)
                        log_mismatch("result mismatch", want, got);
                end
            end
            if (start && !busy) begin
                want = pool_apply(opcode, slot_index);
                owed_results.push_back(cmd_fixed ? cmd_want : want);
            end
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int          n;
        int          alloc_bias;
        int          r;
        logic [1:0]  op;
        logic [7:0]  slot;
        for (n = 0; n < POOL; n++)
            free_slots[n] = 8'(POOL - 1 - n);
        free_depth = POOL;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_cmd(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].fixed,
                     dir_rows[k].want, 1'b1);
        drain_results();

        alloc_bias = 50;
        for (n = 0; n < RAND_ITEMS; n++) begin
            // swing between filling and draining the pool
            if (n % 100 == 0)
                case ($urandom_range(0, 2))
                    0: alloc_bias = 15;
                    1: alloc_bias = 50;
                    default: alloc_bias = 85;
                endcase
            if (n == RAND_ITEMS / 2)
                drain_results();
            r = $urandom_range(0, 99);
            slot = 8'($urandom_range(0, 255));
            if (r < alloc_bias) begin
                op = OP_ALLOC;
            end
            else if (r < 93) begin
                op = OP_RELEASE;
                slot = pick_release_slot();
            end
            else if (r < 97) begin
                op = OP_QUERY;
            end
            else begin
                op = OP_UNUSED;
            end
            send_cmd(op, slot, 1'b0, '0, n < QUIET_FROM);
        end

        drain_results();
        repeat (POOL + 4) @(posedge clk);
        bad_results += owed_results.size();
        if (bad_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
